// ----- rtl/core/atu_pkg.sv -----
package atu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int SUM_W      = PROD_W + 2;
    localparam int NUM_ROWS   = 3;
    localparam int NUM_COLS   = 4;
    localparam int NUM_COEF   = NUM_ROWS * NUM_COLS;
    localparam int IDX_W      = 5;
    localparam int OP_W       = 3;

    localparam logic [OP_W-1:0] OP_LOAD        = 3'd0;
    localparam logic [OP_W-1:0] OP_POINT       = 3'd1;
    localparam logic [OP_W-1:0] OP_VECTOR      = 3'd2;
    localparam logic [OP_W-1:0] OP_NORMAL      = 3'd3;
    localparam logic [OP_W-1:0] OP_REV_POINT   = 3'd4;
    localparam logic [OP_W-1:0] OP_REV_VECTOR  = 3'd5;
    localparam logic [OP_W-1:0] OP_REV_NORMAL  = 3'd6;
    localparam logic [OP_W-1:0] OP_RESERVED    = 3'd7;

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic [NUM_COLS-1:0][DATA_WIDTH-1:0] coef_row_t;
    typedef logic [NUM_ROWS-1:0][NUM_COLS-1:0][DATA_WIDTH-1:0] matrix_t;
    typedef logic [NUM_ROWS-1:0][DATA_WIDTH-1:0] vec_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] index;
        word_t            value;
    } coef_wr_t;

    localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

endpackage

// ----- rtl/core/atu_coef_bank.sv -----
module atu_coef_bank (
    input  logic              clk,
    input  logic              rst_n,
    input  atu_pkg::coef_wr_t wr,
    input  logic              use_fwd,
    output atu_pkg::matrix_t  mat
);
    import atu_pkg::*;

    word_t fwd_reg [NUM_COEF];
    word_t inv_reg [NUM_COEF];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                fwd_reg[i] <= '0;
                inv_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            // indexes past the inverse matrix match nothing and are dropped
            for (int i = 0; i < NUM_COEF; i++)
            begin
                if (wr.index == IDX_W'(i))
                    fwd_reg[i] <= wr.value;
                if (wr.index == IDX_W'(i + NUM_COEF))
                    inv_reg[i] <= wr.value;
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                mat[r][c] = use_fwd ? fwd_reg[r * NUM_COLS + c] : inv_reg[r * NUM_COLS + c];
            end
        end
    end

endmodule

// ----- rtl/core/atu_row.sv -----
module atu_row (
    input  logic               clk,
    input  logic               en,
    input  atu_pkg::coef_row_t coefs,
    input  atu_pkg::vec_t      vec,
    input  logic               translate,
    output atu_pkg::word_t     result
);
    import atu_pkg::*;

    logic signed [PROD_W-1:0] prod_reg  [NUM_COLS];
    logic signed [PROD_W-1:0] prod_next [NUM_COLS];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  shifted;
    logic [SUM_W-DATA_WIDTH:0] upper;
    word_t                    result_reg;
    word_t                    result_next;

    always_comb
    begin
        for (int c = 0; c < NUM_ROWS; c++)
        begin
            prod_next[c] = PROD_W'($signed(coefs[c])) * PROD_W'($signed(vec[c]));
        end
        // translation column scaled by one in fixed point
        prod_next[NUM_COLS-1] = translate ?
            (PROD_W'($signed(coefs[NUM_COLS-1])) <<< FRAC_BITS) : '0;
    end

    assign sum_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
                    + SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]);

    assign shifted = sum_reg >>> FRAC_BITS;
    assign upper   = shifted[SUM_W-1:DATA_WIDTH-1];

    always_comb
    begin
        if ((&upper) || !(|upper))
            result_next = shifted[DATA_WIDTH-1:0];
        else if (shifted[SUM_W-1])
            result_next = WORD_MIN;
        else
            result_next = WORD_MAX;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                prod_reg[c] <= prod_next[c];
            end
            sum_reg    <= sum_next;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- rtl/core/affine_transform_unit_top.sv -----
// Affine transform unit: 3x4 forward and inverse matrices, signed Q16.16.
//
// Input channel (in_valid/in_ready) carries opcode, coef_index, coef_value
// and the vector in_x/in_y/in_z. A load item writes one coefficient at the
// accepting edge and gives no result; opcode seven gives no result either.
// Every other item produces one result on the output channel
// (out_valid/out_ready) with out_x/out_y/out_z.
//
// Pipeline: matrix and vector registered at the accepting edge, then nine
// 32x32 multiplies into the product registers, row sum into the sum
// register, shift and saturate into the output register.
// Throughput: one item per cycle, loads included, while no result waits on a low out_ready.
// A load takes effect for every item accepted after it.
//
// Reset clears both matrices to zero and empties the pipeline.
// While a result waits on a low out_ready, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
module affine_transform_unit_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [atu_pkg::OP_W-1:0]           opcode,
    input  logic [atu_pkg::IDX_W-1:0]          coef_index,
    input  logic signed [atu_pkg::DATA_WIDTH-1:0] coef_value,
    input  logic signed [atu_pkg::DATA_WIDTH-1:0] in_x,
    input  logic signed [atu_pkg::DATA_WIDTH-1:0] in_y,
    input  logic signed [atu_pkg::DATA_WIDTH-1:0] in_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [atu_pkg::DATA_WIDTH-1:0] out_x,
    output logic signed [atu_pkg::DATA_WIDTH-1:0] out_y,
    output logic signed [atu_pkg::DATA_WIDTH-1:0] out_z
);
    import atu_pkg::*;

    logic     advance;
    logic     accept;
    logic     is_xform;
    logic     use_fwd;
    logic     translate;
    coef_wr_t wr;
    matrix_t  mat_sel;

    matrix_t  mat_reg;
    vec_t     vec_reg;
    logic     trans_reg;

    logic     s1_valid_reg;
    logic     s2_valid_reg;
    logic     s3_valid_reg;
    logic     out_valid_reg;
    logic     s1_valid_next;

    word_t    row_out [NUM_ROWS];

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && advance;

    assign is_xform  = (opcode != OP_LOAD) && (opcode != OP_RESERVED);
    assign use_fwd   = opcode inside {OP_POINT, OP_VECTOR, OP_REV_NORMAL};
    assign translate = opcode inside {OP_POINT, OP_REV_POINT};

    assign wr.en    = accept && (opcode == OP_LOAD);
    assign wr.index = coef_index;
    assign wr.value = coef_value;

    assign s1_valid_next = accept && is_xform;

    atu_coef_bank u_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .use_fwd (use_fwd),
        .mat     (mat_sel)
    );

    // capture coefficients at accept so later loads do not reach this item
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mat_reg    <= mat_sel;
            vec_reg[0] <= in_x;
            vec_reg[1] <= in_y;
            vec_reg[2] <= in_z;
            trans_reg  <= translate;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    for (genvar r = 0; r < NUM_ROWS; r++)
    begin : g_row
        atu_row u_row (
            .clk       (clk),
            .en        (advance),
            .coefs     (mat_reg[r]),
            .vec       (vec_reg),
            .translate (trans_reg),
            .result    (row_out[r])
        );
    end

    assign out_valid = out_valid_reg;
    assign out_x     = row_out[0];
    assign out_y     = row_out[1];
    assign out_z     = row_out[2];

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (opcode == OP_LOAD)) |=> !s1_valid_reg)
        else $error("load item entered the transform pipeline");

    a_xform_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (opcode != OP_LOAD) && (opcode != OP_RESERVED))
        |=> s1_valid_reg)
        else $error("transform item dropped at entry");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready)
        |=> ($stable(s1_valid_reg) && $stable(s2_valid_reg) && $stable(s3_valid_reg)))
        else $error("pipeline moved during output stall");

    a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s3_valid_reg) |=> out_valid_reg)
        else $error("item lost between last stage and output");

endmodule
